@@ rtl/core/pcf_pkg.sv @@
// ----------------------------------------------------------------------------
// pcf_pkg: shared types and constants of the pixel color filter
// Mode codes, the color-vision coefficient table and the fixed palettes.
// ----------------------------------------------------------------------------
package pcf_pkg;

  typedef logic [3:0]  mode_t;
  typedef logic [7:0]  chan_t;
  typedef logic [15:0] coef_t;

  localparam mode_t MODE_OFF         = 4'd0;
  localparam mode_t MODE_PROTANOMALY = 4'd1;
  localparam mode_t MODE_PROTANOPIA  = 4'd2;
  localparam mode_t MODE_DEUTERANOM  = 4'd3;
  localparam mode_t MODE_DEUTERANOPE = 4'd4;
  localparam mode_t MODE_TRITANOMALY = 4'd5;
  localparam mode_t MODE_TRITANOPIA  = 4'd6;
  localparam mode_t MODE_GREY        = 4'd7;
  localparam mode_t MODE_EIGHT       = 4'd8;
  localparam mode_t MODE_332         = 4'd9;
  localparam mode_t MODE_SHADE       = 4'd10;

  localparam int NUM_COEF = 9;

  // Q0.16 coefficients, row-major: red row, green row, blue row
  localparam coef_t MTX [0:5][0:NUM_COEF-1] = '{
    '{16'd53521, 16'd12015, 16'd0, 16'd21845, 16'd43691, 16'd0,
      16'd0, 16'd8192, 16'd57344},
    '{16'd37137, 16'd28399, 16'd0, 16'd36591, 16'd28945, 16'd0,
      16'd0, 16'd15838, 16'd49698},
    '{16'd52429, 16'd13107, 16'd0, 16'd16930, 16'd48606, 16'd0,
      16'd0, 16'd9284, 16'd56252},
    '{16'd40960, 16'd24576, 16'd0, 16'd45875, 16'd19661, 16'd0,
      16'd0, 16'd19661, 16'd45875},
    '{16'd63352, 16'd2184, 16'd0, 16'd0, 16'd48060, 16'd17476,
      16'd0, 16'd12015, 16'd53521},
    '{16'd62259, 16'd3277, 16'd0, 16'd0, 16'd28399, 16'd37137,
      16'd0, 16'd31130, 16'd34406}
  };

  localparam chan_t EIGHT_PAL [0:7] = '{
    8'd0, 8'd52, 8'd87, 8'd116, 8'd144, 8'd172, 8'd206, 8'd255
  };

  localparam chan_t SHADE_PAL [0:3][0:2] = '{
    '{8'd12,  8'd54,  8'd14},
    '{8'd44,  8'd98,  8'd52},
    '{8'd110, 8'd135, 8'd10},
    '{8'd156, 8'd190, 8'd12}
  };

  // Coefficient k of the matrix for a mode; zero outside the matrix modes.
  function automatic coef_t mtx_coef(mode_t mode, int k);
    coef_t c;
    c = '0;
    case (mode) inside
      [MODE_PROTANOMALY:MODE_TRITANOPIA]: c = MTX[3'(mode - 4'd1)][k];
      default: c = '0;
    endcase
    return c;
  endfunction

  // Eight-level quantizer: level (c+8)>>5, clamped to 7.
  function automatic chan_t eight_level(chan_t c);
    logic [8:0] biased;
    logic [3:0] lvl;
    biased = {1'b0, c} + 9'd8;
    lvl    = biased[8:5];
    return (lvl > 4'd7) ? EIGHT_PAL[7] : EIGHT_PAL[lvl[2:0]];
  endfunction

endpackage

@@ rtl/core/pcf_in_if.sv @@
// ----------------------------------------------------------------------------
// pcf_in_if: source pixel channel
// Valid/ready handshake carrying one RGBA8 pixel per transfer.
// ----------------------------------------------------------------------------
interface pcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

@@ rtl/core/pcf_out_if.sv @@
// ----------------------------------------------------------------------------
// pcf_out_if: filtered pixel channel
// Valid/ready handshake carrying one filtered RGBA8 pixel per transfer.
// ----------------------------------------------------------------------------
interface pcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

@@ rtl/core/pixel_color_filter.sv @@
// ----------------------------------------------------------------------------
// pixel_color_filter: per-pixel RGBA8 color filter
// An input transfer is registered in stage 1, then stage 2, then the stage 3
// output register, which drives output valid.
// Throughput: one pixel per cycle while the sink keeps ready high; each of the
// three stages holds its own item and advances when the next stage is empty or moving.
// Reset (rst, synchronous): pipeline emptied, filter_mode back to off.
// ----------------------------------------------------------------------------
module pixel_color_filter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  pcf_pkg::mode_t       cfg_wr_data,
  pcf_in_if.sink               pix_in,
  pcf_out_if.source            pix_out
);
  import pcf_pkg::*;

  localparam int PW = 24;  // 8 x 16 product
  localparam int SW = 25;  // row sum

  mode_t filter_mode;

  // stage 1: products and channel sum
  logic          v1;
  mode_t         mode1;
  chan_t         r1, g1, b1, a1;
  logic [PW-1:0] prod1 [0:NUM_COEF-1];
  logic [9:0]    sum1;

  // stage 2: row sums, grey and shade index
  logic          v2;
  mode_t         mode2;
  chan_t         r2, g2, b2, a2;
  logic [SW-1:0] row2 [0:2];
  chan_t         grey2;
  logic [1:0]    shade2;

  // stage 3: output register
  logic          v3;
  chan_t         r3, g3, b3, a3;

  logic          en1, en2, en3;
  logic [PW-1:0] prod_next [0:NUM_COEF-1];
  logic [SW-1:0] row_next [0:2];
  logic [19:0]   grey_prod;
  logic [1:0]    shade_next;
  chan_t         r3_next, g3_next, b3_next;
  chan_t         sat2 [0:2];

  assign en3 = !v3 || pix_out.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign pix_in.ready      = en1;
  assign pix_out.valid     = v3;
  assign pix_out.red_out   = r3;
  assign pix_out.green_out = g3;
  assign pix_out.blue_out  = b3;
  assign pix_out.alpha_out = a3;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_OFF;
    end else if (cfg_wr_en) begin
      filter_mode <= cfg_wr_data;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_COEF; k++) begin
      case (k % 3)
        0:       prod_next[k] = PW'(pix_in.red_in)   * PW'(mtx_coef(filter_mode, k));
        1:       prod_next[k] = PW'(pix_in.green_in) * PW'(mtx_coef(filter_mode, k));
        default: prod_next[k] = PW'(pix_in.blue_in)  * PW'(mtx_coef(filter_mode, k));
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= pix_in.valid;
    end
    if (en1) begin
      mode1 <= filter_mode;
      r1    <= pix_in.red_in;
      g1    <= pix_in.green_in;
      b1    <= pix_in.blue_in;
      a1    <= pix_in.alpha_in;
      sum1  <= 10'(pix_in.red_in) + 10'(pix_in.green_in) + 10'(pix_in.blue_in);
      for (int k = 0; k < NUM_COEF; k++) begin
        prod1[k] <= prod_next[k];
      end
    end
  end

  // floor(s/3) = (s*683)>>11 holds exactly for s up to 765
  assign grey_prod = 20'(sum1) * 20'd683;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_next[i] = SW'(prod1[3*i]) + SW'(prod1[3*i+1]) + SW'(prod1[3*i+2]);
    end
    if (sum1 >= 10'd576) begin
      shade_next = 2'd3;
    end else if (sum1 >= 10'd384) begin
      shade_next = 2'd2;
    end else if (sum1 >= 10'd192) begin
      shade_next = 2'd1;
    end else begin
      shade_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      mode2  <= mode1;
      r2     <= r1;
      g2     <= g1;
      b2     <= b1;
      a2     <= a1;
      grey2  <= grey_prod[18:11];
      shade2 <= shade_next;
      for (int i = 0; i < 3; i++) begin
        row2[i] <= row_next[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat2[i] = row2[i][SW-1] ? 8'hFF : row2[i][23:16];
    end
    r3_next = r2;
    g3_next = g2;
    b3_next = b2;
    case (mode2) inside
      [MODE_PROTANOMALY:MODE_TRITANOPIA]: begin
        r3_next = sat2[0];
        g3_next = sat2[1];
        b3_next = sat2[2];
      end
      MODE_GREY: begin
        r3_next = grey2;
        g3_next = grey2;
        b3_next = grey2;
      end
      MODE_EIGHT: begin
        r3_next = eight_level(r2);
        g3_next = eight_level(g2);
        b3_next = eight_level(b2);
      end
      MODE_332: begin
        r3_next = {r2[7:5], 5'd16};
        g3_next = {g2[7:5], 5'd16};
        b3_next = {b2[7:6], 6'd32};
      end
      MODE_SHADE: begin
        r3_next = SHADE_PAL[shade2][0];
        g3_next = SHADE_PAL[shade2][1];
        b3_next = SHADE_PAL[shade2][2];
      end
      default: begin
        // pass the pixel through
        r3_next = r2;
        g3_next = g2;
        b3_next = b2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      r3 <= r3_next;
      g3 <= g3_next;
      b3 <= b3_next;
      a3 <= a2;
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: pixel_color_filter self-checking bench
// Streams RGBA8 pixels through the filter under random source gaps and sink
// back-pressure, then compares each filtered pixel with a behavioral
// prediction of the active filter mode. Directed pixels hit full-scale,
// quantizer and palette boundaries and cover every mode code; random phases follow.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcf_pkg::*;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } pixel_t;

  localparam int RANDOM_PIXELS = 600;
  localparam int LONG_HOLD     = 48;
  localparam int STALL_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 8;

  logic  clk;
  logic  rst;
  logic  cfg_wr_en;
  mode_t cfg_wr_data;

  pcf_in_if  pix_in ();
  pcf_out_if pix_out ();

  pixel_color_filter i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .pix_in     (pix_in),
    .pix_out    (pix_out)
  );

  pixel_t pending_px [$];
  pixel_t filtered_px [$];
  pixel_t offered;
  mode_t  cur_mode;
  logic   steady;
  int     send_gap;
  int     sink_hold;
  int     hold_requests;
  int     hold_served;
  int     idle_cycles;
  int     n_in;
  int     n_out;
  int     n_settings;
  int     errors;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Expected filter output for one pixel under a given mode
  function automatic pixel_t filtered_pixel(mode_t m, pixel_t px);
    chan_t       src [3];
    chan_t       dst [3];
    int unsigned acc;
    int unsigned lvl;
    int unsigned shade;
    src = '{px.red, px.green, px.blue};
    dst = src;
    case (m)
      MODE_PROTANOMALY, MODE_PROTANOPIA, MODE_DEUTERANOM,
      MODE_DEUTERANOPE, MODE_TRITANOMALY, MODE_TRITANOPIA: begin
        for (int i = 0; i < 3; i++) begin
          acc = (int'(src[0]) * int'(MTX[m - 1][3 * i])
               + int'(src[1]) * int'(MTX[m - 1][3 * i + 1])
               + int'(src[2]) * int'(MTX[m - 1][3 * i + 2])) >> 16;
          dst[i] = (acc > 255) ? 8'd255 : acc[7:0];
        end
      end
      MODE_GREY: begin
        acc = (int'(src[0]) + int'(src[1]) + int'(src[2])) / 3;
        dst = '{acc[7:0], acc[7:0], acc[7:0]};
      end
      MODE_EIGHT: begin
        for (int i = 0; i < 3; i++) begin
          lvl = (int'(src[i]) + 8) >> 5;
          dst[i] = EIGHT_PAL[(lvl > 7) ? 7 : lvl];
        end
      end
      MODE_332: begin
        dst[0] = {src[0][7:5], 5'd16};
        dst[1] = {src[1][7:5], 5'd16};
        dst[2] = {src[2][7:6], 6'd32};
      end
      MODE_SHADE: begin
        shade = (4 * (int'(src[0]) + int'(src[1]) + int'(src[2]))) / 768;
        if (shade > 3) shade = 3;
        for (int i = 0; i < 3; i++) dst[i] = SHADE_PAL[shade][i];
      end
      default: dst = src;
    endcase
    return '{red: dst[0], green: dst[1], blue: dst[2], alpha: px.alpha};
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(4, 24);
    return $urandom_range(1, 3);
  endfunction

  function automatic chan_t random_chan();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic check_chan(string field, chan_t want, chan_t got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Source side: offer pending pixels, record a prediction on each transfer
  always @(posedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        filtered_px.push_back(filtered_pixel(cur_mode, offered));
        n_in++;
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pix_in.valid <= 1'b0;
        end else if (pending_px.size() > 0) begin
          offered = pending_px.pop_front();
          pix_in.red_in   <= offered.red;
          pix_in.green_in <= offered.green;
          pix_in.blue_in  <= offered.blue;
          pix_in.alpha_in <= offered.alpha;
          pix_in.valid    <= 1'b1;
          send_gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: compare each transfer, apply random and long back-pressure
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst) begin
      pix_out.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        got = '{pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.alpha_out};
        n_out++;
        if (filtered_px.size() == 0) begin
          $display("%0t ns: unexpected pixel, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = filtered_px.pop_front();
          check_chan("red_out", want.red, got.red);
          check_chan("green_out", want.green, got.green);
          check_chan("blue_out", want.blue, got.blue);
          check_chan("alpha_out", want.alpha, got.alpha);
        end
      end
      if (hold_served < hold_requests) begin
        hold_served++;
        sink_hold = LONG_HOLD;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        pix_out.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        sink_hold = idle_length() - 1;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_px.size() != 0 || pix_in.valid || filtered_px.size() != 0);
  endtask

  task automatic set_mode(mode_t m);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = m;
    n_settings++;
  endtask

  task automatic send(chan_t r, chan_t g, chan_t b, chan_t a);
    pending_px.push_back('{red: r, green: g, blue: b, alpha: a});
  endtask

  initial begin
    int     queued;
    int     count;
    int     phase;
    mode_t  m;
    pixel_t px;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = MODE_OFF;
    pix_in.valid  = 1'b0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_in.alpha_in = '0;
    pix_out.ready = 1'b0;
    cur_mode      = MODE_OFF;
    steady        = 1'b0;
    hold_requests = 0;
    hold_served   = 0;
    idle_cycles   = 0;
    n_in          = 0;
    n_out         = 0;
    n_settings    = 0;
    errors        = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: pass-through after reset, then every mode code
    send(8'd0, 8'd0, 8'd0, 8'd0);
    send(8'd255, 8'd255, 8'd255, 8'd255);
    send(8'hAA, 8'h55, 8'hA5, 8'h5A);
    for (int k = 1; k <= 6; k++) begin
      set_mode(mode_t'(k));
      // white drives every row to full scale, 255, without overflow
      send(8'd255, 8'd255, 8'd255, 8'(k * 37));
    end
    set_mode(MODE_GREY);
    send(8'd255, 8'd255, 8'd254, 8'd1);
    set_mode(MODE_EIGHT);
    // level clamp at the top, level steps at the bottom
    send(8'd247, 8'd248, 8'd7, 8'd128);
    send(8'd8, 8'd24, 8'd255, 8'd127);
    set_mode(MODE_332);
    send(8'd255, 8'd31, 8'd63, 8'd64);
    set_mode(MODE_SHADE);
    // each side of every shade boundary
    send(8'd191, 8'd0, 8'd0, 8'd2);
    send(8'd64, 8'd64, 8'd64, 8'd4);
    send(8'd255, 8'd128, 8'd0, 8'd8);
    send(8'd128, 8'd128, 8'd128, 8'd16);
    send(8'd255, 8'd255, 8'd65, 8'd32);
    send(8'd255, 8'd255, 8'd66, 8'd253);
    // undefined codes pass the pixel through
    for (int k = 11; k <= 15; k++) begin
      set_mode(mode_t'(k));
      send(8'd200, 8'd100, 8'd50, 8'(k));
    end

    // Random phases, one mode setting each
    queued = 0;
    phase  = 0;
    while (queued < RANDOM_PIXELS) begin
      if (phase == 0) m = MODE_SHADE;
      else if (phase == 1) m = MODE_OFF;
      else if ($urandom_range(0, 7) == 0) m = mode_t'($urandom_range(11, 15));
      else m = mode_t'($urandom_range(0, 10));
      set_mode(m);
      count  = $urandom_range(10, 60);
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 2 || phase == 8) begin
        // hold the sink off while the source keeps offering
        count  = 100;
        steady = 1'b1;
        hold_requests++;
      end
      for (int k = 0; k < count; k++) begin
        px = '{random_chan(), random_chan(), random_chan(), random_chan()};
        pending_px.push_back(px);
      end
      queued += count;
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (filtered_px.size() != 0) begin
      $display("%0t ns: %0d filtered pixels never arrived", $time, filtered_px.size());
      errors++;
    end
    $display("Filtered %0d of %0d pixels over %0d mode writes, all sixteen mode codes used,",
             n_out, n_in, n_settings);
    $display("with random source gaps, sink back-pressure and two long sink hold-offs.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
